// ===== design/ck_pkg.sv =====
// Shared types, constants and helper functions for the chroma key alpha block.
// Used by every module of the block; it depends on nothing else.
package ck_pkg;

  // Field widths.
  localparam int CK_PIX_W  = 8;   // one color byte
  localparam int CK_DIST_W = 18;  // squared distance and radii
  localparam int CK_SQ_W   = 16;  // one squared component difference
  localparam int CK_NUM_W  = 26;  // 255 times a distance difference
  localparam int CK_QUO_W  = 8;   // alpha quotient

  // Configuration port.
  localparam int CK_CFG_IDX_W = 3;
  localparam logic [CK_CFG_IDX_W-1:0] CK_REG_KEY_RED   = 3'd0;
  localparam logic [CK_CFG_IDX_W-1:0] CK_REG_KEY_GREEN = 3'd1;
  localparam logic [CK_CFG_IDX_W-1:0] CK_REG_KEY_BLUE  = 3'd2;
  localparam logic [CK_CFG_IDX_W-1:0] CK_REG_INNER_SQ  = 3'd3;
  localparam logic [CK_CFG_IDX_W-1:0] CK_REG_OUTER_SQ  = 3'd4;

  localparam logic [CK_PIX_W-1:0]  CK_RST_KEY_RED   = 8'd55;
  localparam logic [CK_PIX_W-1:0]  CK_RST_KEY_GREEN = 8'd177;
  localparam logic [CK_PIX_W-1:0]  CK_RST_KEY_BLUE  = 8'd77;
  localparam logic [CK_DIST_W-1:0] CK_RST_INNER_SQ  = 18'd6400;
  localparam logic [CK_DIST_W-1:0] CK_RST_OUTER_SQ  = 18'd14400;

  localparam logic [CK_PIX_W-1:0] CK_ALPHA_OPAQUE = 8'd255;
  localparam logic [CK_PIX_W-1:0] CK_ALPHA_CLEAR  = 8'd0;

  // Queue between classifier and divider.
  localparam int CK_QDEPTH = 4;
  localparam int CK_QPTR_W = $clog2(CK_QDEPTH);
  localparam int CK_QCNT_W = $clog2(CK_QDEPTH + 1);

  // Number of restoring divide stages, one quotient bit each.
  localparam int CK_DIV_STAGES = CK_QUO_W;

  // Classification of a pixel against the two radii.
  typedef enum logic [1:0] {
    CK_CLS_ZERO,
    CK_CLS_FULL,
    CK_CLS_RAMP
  } ck_cls_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [CK_PIX_W-1:0]  red;
    logic [CK_PIX_W-1:0]  green;
    logic [CK_PIX_W-1:0]  blue;
    ck_cls_t              cls;
    logic [CK_DIST_W-1:0] diff;
    logic [CK_DIST_W-1:0] den;
  } ck_item_t;

  // Queue status seen by the classifier and the divider.
  typedef struct packed {
    logic full;
    logic empty;
  } ck_qstat_t;

  // One item inside the divider pipeline.
  typedef struct packed {
    logic                 v;
    logic [CK_PIX_W-1:0]  red;
    logic [CK_PIX_W-1:0]  green;
    logic [CK_PIX_W-1:0]  blue;
    ck_cls_t              cls;
    logic [CK_NUM_W-1:0]  rem;
    logic [CK_DIST_W-1:0] den;
    logic [CK_QUO_W-1:0]  quo;
  } ck_div_t;

  // Absolute difference of two color bytes.
  function automatic logic [CK_PIX_W-1:0] ck_absdiff(input logic [CK_PIX_W-1:0] a,
                                                     input logic [CK_PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== design/ck_front.sv =====
// Classifier front end: squares the color differences, sums them and sorts the
// item against the two radii before pushing it into the queue. Uses ck_pkg.
module ck_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ck_pkg::CK_PIX_W-1:0]   in_red,
  input  logic [ck_pkg::CK_PIX_W-1:0]   in_green,
  input  logic [ck_pkg::CK_PIX_W-1:0]   in_blue,
  input  logic [ck_pkg::CK_PIX_W-1:0]   key_red,
  input  logic [ck_pkg::CK_PIX_W-1:0]   key_green,
  input  logic [ck_pkg::CK_PIX_W-1:0]   key_blue,
  input  logic [ck_pkg::CK_DIST_W-1:0]  inner_sq,
  input  logic [ck_pkg::CK_DIST_W-1:0]  outer_sq,
  input  ck_pkg::ck_qstat_t             qstat,
  output logic                          push,
  output ck_pkg::ck_item_t              push_item
);

  logic                         adv;
  logic [ck_pkg::CK_PIX_W-1:0]  dr, dg, db;

  // Stage one: squared component differences.
  logic                         v1_r, v1_nxt;
  logic [ck_pkg::CK_PIX_W-1:0]  red1_r, green1_r, blue1_r;
  logic [ck_pkg::CK_SQ_W-1:0]   sqr_r, sqg_r, sqb_r;
  logic [ck_pkg::CK_SQ_W-1:0]   sqr_nxt, sqg_nxt, sqb_nxt;

  // Stage two: full squared distance.
  logic                         v2_r, v2_nxt;
  logic [ck_pkg::CK_PIX_W-1:0]  red2_r, green2_r, blue2_r;
  logic [ck_pkg::CK_DIST_W-1:0] dist_r, dist_nxt;

  // The whole front moves together; it only holds when its last item cannot be queued.
  assign adv      = !v2_r || !qstat.full;
  assign in_stall = !adv;
  assign push     = v2_r && !qstat.full;

  always_comb begin
    dr       = ck_pkg::ck_absdiff(in_red, key_red);
    dg       = ck_pkg::ck_absdiff(in_green, key_green);
    db       = ck_pkg::ck_absdiff(in_blue, key_blue);
    sqr_nxt  = dr * dr;
    sqg_nxt  = dg * dg;
    sqb_nxt  = db * db;
    v1_nxt   = in_valid;
    v2_nxt   = v1_r;
    dist_nxt = ck_pkg::CK_DIST_W'(sqr_r) + ck_pkg::CK_DIST_W'(sqg_r)
             + ck_pkg::CK_DIST_W'(sqb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red1_r   <= in_red;
      green1_r <= in_green;
      blue1_r  <= in_blue;
      sqr_r    <= sqr_nxt;
      sqg_r    <= sqg_nxt;
      sqb_r    <= sqb_nxt;
      red2_r   <= red1_r;
      green2_r <= green1_r;
      blue2_r  <= blue1_r;
      dist_r   <= dist_nxt;
    end
  end

  // Sort the distance into clear, opaque or ramp. The ramp is only possible when
  // the outer radius lies above the inner one, so its denominator is never zero.
  always_comb begin
    push_item.red   = red2_r;
    push_item.green = green2_r;
    push_item.blue  = blue2_r;
    push_item.den   = outer_sq - inner_sq;
    push_item.diff  = '0;
    if (dist_r < inner_sq) begin
      push_item.cls = ck_pkg::CK_CLS_ZERO;
    end else if (dist_r >= outer_sq) begin
      push_item.cls = ck_pkg::CK_CLS_FULL;
    end else begin
      push_item.cls  = ck_pkg::CK_CLS_RAMP;
      push_item.diff = dist_r - inner_sq;
    end
  end

endmodule

// ===== design/ck_queue.sv =====
// Short item queue that decouples the classifier from the divider pipeline.
// Uses the item and status types of ck_pkg.
module ck_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ck_pkg::ck_item_t  push_item,
  input  logic              pop,
  output ck_pkg::ck_item_t  pop_item,
  output ck_pkg::ck_qstat_t qstat
);

  ck_pkg::ck_item_t               mem_r [0:ck_pkg::CK_QDEPTH-1];
  logic [ck_pkg::CK_QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ck_pkg::CK_QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ck_pkg::CK_QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == ck_pkg::CK_QCNT_W'(ck_pkg::CK_QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

endmodule

// ===== design/ck_back.sv =====
// Divider back end: forms 255 times the distance past the inner radius and
// divides it by the ramp width, one quotient bit per stage. Uses ck_pkg.
module ck_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ck_pkg::ck_qstat_t           qstat,
  input  ck_pkg::ck_item_t            pop_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ck_pkg::CK_PIX_W-1:0] out_red,
  output logic [ck_pkg::CK_PIX_W-1:0] out_green,
  output logic [ck_pkg::CK_PIX_W-1:0] out_blue,
  output logic [ck_pkg::CK_PIX_W-1:0] out_alpha
);

  localparam int LAST = ck_pkg::CK_DIV_STAGES;

  logic                        adv;
  ck_pkg::ck_div_t             st_r   [0:LAST];
  ck_pkg::ck_div_t             st_nxt [0:LAST];

  logic                        out_v_r, out_v_nxt;
  logic [ck_pkg::CK_PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [ck_pkg::CK_PIX_W-1:0] out_alpha_r, alpha_nxt;

  // Every stage moves together whenever the output register can be refilled.
  assign adv = !out_v_r || !out_stall;
  assign pop = adv && !qstat.empty;

  // Entry stage: 255 * diff is diff * 256 - diff.
  always_comb begin
    st_nxt[0].v     = pop;
    st_nxt[0].red   = pop_item.red;
    st_nxt[0].green = pop_item.green;
    st_nxt[0].blue  = pop_item.blue;
    st_nxt[0].cls   = pop_item.cls;
    st_nxt[0].den   = pop_item.den;
    st_nxt[0].quo   = '0;
    st_nxt[0].rem   = {pop_item.diff, 8'b0} - ck_pkg::CK_NUM_W'(pop_item.diff);
  end

  // Restoring division. The quotient of a ramp item is below 255, so eight bits
  // suffice and the first stage tries the divisor shifted up by seven.
  for (genvar s = 0; s < ck_pkg::CK_DIV_STAGES; s++) begin : g_div
    localparam int K = ck_pkg::CK_DIV_STAGES - 1 - s;
    logic [ck_pkg::CK_NUM_W-1:0] dsh;
    logic [ck_pkg::CK_NUM_W:0]   dif;

    assign dsh = ck_pkg::CK_NUM_W'(st_r[s].den) << K;
    assign dif = {1'b0, st_r[s].rem} - {1'b0, dsh};

    always_comb begin
      st_nxt[s+1] = st_r[s];
      if (!dif[ck_pkg::CK_NUM_W]) begin
        st_nxt[s+1].rem    = dif[ck_pkg::CK_NUM_W-1:0];
        st_nxt[s+1].quo[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) begin
        st_r[i].v <= 1'b0;
      end
    end else if (adv) begin
      for (int i = 0; i <= LAST; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_comb begin
    out_v_nxt = st_r[LAST].v;
    case (st_r[LAST].cls)
      ck_pkg::CK_CLS_ZERO: alpha_nxt = ck_pkg::CK_ALPHA_CLEAR;
      ck_pkg::CK_CLS_FULL: alpha_nxt = ck_pkg::CK_ALPHA_OPAQUE;
      ck_pkg::CK_CLS_RAMP: alpha_nxt = st_r[LAST].quo;
      default:             alpha_nxt = ck_pkg::CK_ALPHA_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r   <= st_r[LAST].red;
      out_green_r <= st_r[LAST].green;
      out_blue_r  <= st_r[LAST].blue;
      out_alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r[LAST].v && st_r[LAST].cls == ck_pkg::CK_CLS_RAMP)
      |-> (st_r[LAST].rem < ck_pkg::CK_NUM_W'(st_r[LAST].den)))
    else $error("divider remainder not below the ramp width");

  a_ramp_not_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r[LAST].v && st_r[LAST].cls == ck_pkg::CK_CLS_RAMP)
      |-> (st_r[LAST].quo != ck_pkg::CK_ALPHA_OPAQUE))
    else $error("ramp quotient reached full opacity");

endmodule

// ===== design/chroma_key_alpha_core.sv =====
// Chroma key alpha core: passes an RGB pixel through and adds an alpha byte that
// grows with the squared distance to a programmable key color. Uses ck_pkg,
// ck_front, ck_queue and ck_back.
//
// The block takes one pixel item per clock while in_stall is low and returns one
// result item per pixel, in order, with the color bytes unchanged. A pixel
// passes through the classifier stages (squares, then their sum and the
// compares against the radii), the four-entry queue, an entry stage that forms
// 255 times the distance past the inner radius, the divider stages (one
// restoring step, one quotient bit per stage) and the output register. Alpha
// is 0 below the inner squared radius, otherwise 255 at or beyond the outer
// one, and floor(255*(d-inner)/(outer-inner)) in between; when the outer
// radius is not above the inner one there is no ramp. The divider pipeline
// holds as a whole while the output is stalled and the queue absorbs the
// classifier's items, so the input stalls only once the queue is full.
// Registers may be written at any time the write channel is valid
// (cfg_ready is always high), but are meant to change only while no pixel is in
// flight. Writes to an index outside the register list are ignored.
module chroma_key_alpha_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Pixel input.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ck_pkg::CK_PIX_W-1:0]       in_red,
  input  logic [ck_pkg::CK_PIX_W-1:0]       in_green,
  input  logic [ck_pkg::CK_PIX_W-1:0]       in_blue,
  // Result output.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ck_pkg::CK_PIX_W-1:0]       out_red,
  output logic [ck_pkg::CK_PIX_W-1:0]       out_green,
  output logic [ck_pkg::CK_PIX_W-1:0]       out_blue,
  output logic [ck_pkg::CK_PIX_W-1:0]       out_alpha,
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ck_pkg::CK_CFG_IDX_W-1:0]   cfg_index,
  input  logic [ck_pkg::CK_DIST_W-1:0]      cfg_data
);

  // Configuration registers and their next values.
  logic [ck_pkg::CK_PIX_W-1:0]  key_red_r, key_red_nxt;
  logic [ck_pkg::CK_PIX_W-1:0]  key_green_r, key_green_nxt;
  logic [ck_pkg::CK_PIX_W-1:0]  key_blue_r, key_blue_nxt;
  logic [ck_pkg::CK_DIST_W-1:0] inner_sq_r, inner_sq_nxt;
  logic [ck_pkg::CK_DIST_W-1:0] outer_sq_r, outer_sq_nxt;

  // Links between classifier, queue and divider.
  logic              push;
  logic              pop;
  ck_pkg::ck_item_t  push_item;
  ck_pkg::ck_item_t  pop_item;
  ck_pkg::ck_qstat_t qstat;

  // The register file never back-pressures a write.
  assign cfg_ready = 1'b1;

  // Decode a write; data is truncated to the width of the addressed register.
  always_comb begin
    key_red_nxt   = key_red_r;
    key_green_nxt = key_green_r;
    key_blue_nxt  = key_blue_r;
    inner_sq_nxt  = inner_sq_r;
    outer_sq_nxt  = outer_sq_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ck_pkg::CK_REG_KEY_RED:   key_red_nxt   = cfg_data[ck_pkg::CK_PIX_W-1:0];
        ck_pkg::CK_REG_KEY_GREEN: key_green_nxt = cfg_data[ck_pkg::CK_PIX_W-1:0];
        ck_pkg::CK_REG_KEY_BLUE:  key_blue_nxt  = cfg_data[ck_pkg::CK_PIX_W-1:0];
        ck_pkg::CK_REG_INNER_SQ:  inner_sq_nxt  = cfg_data;
        ck_pkg::CK_REG_OUTER_SQ:  outer_sq_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= ck_pkg::CK_RST_KEY_RED;
      key_green_r <= ck_pkg::CK_RST_KEY_GREEN;
      key_blue_r  <= ck_pkg::CK_RST_KEY_BLUE;
      inner_sq_r  <= ck_pkg::CK_RST_INNER_SQ;
      outer_sq_r  <= ck_pkg::CK_RST_OUTER_SQ;
    end else begin
      key_red_r   <= key_red_nxt;
      key_green_r <= key_green_nxt;
      key_blue_r  <= key_blue_nxt;
      inner_sq_r  <= inner_sq_nxt;
      outer_sq_r  <= outer_sq_nxt;
    end
  end

  // Front end: distance and classification.
  ck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .key_red   (key_red_r),
    .key_green (key_green_r),
    .key_blue  (key_blue_r),
    .inner_sq  (inner_sq_r),
    .outer_sq  (outer_sq_r),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue that lets the two halves stall independently.
  ck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // Back end: ramp division and output register.
  ck_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for chroma_key_alpha_core: directed and random pixel items,
// random idling on both channels and a long output hold-off to fill the block.
// Depends on ck_pkg and the chroma_key_alpha_core RTL.
module tb_top;

  // Drain margin after the last expected result.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int CALM_PHASE   = 4;
  localparam logic [ck_pkg::CK_DIST_W-1:0] MAX_DIST_SQ = 18'd195075;
  localparam logic [ck_pkg::CK_DIST_W-1:0] ALL_ONES_SQ = '1;

  // One result item: the pixel passed through plus its alpha.
  typedef struct packed {
    logic [ck_pkg::CK_PIX_W-1:0] red;
    logic [ck_pkg::CK_PIX_W-1:0] green;
    logic [ck_pkg::CK_PIX_W-1:0] blue;
    logic [ck_pkg::CK_PIX_W-1:0] alpha;
  } keyed_pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            in_valid;
  logic                            in_stall;
  logic [ck_pkg::CK_PIX_W-1:0]     in_red;
  logic [ck_pkg::CK_PIX_W-1:0]     in_green;
  logic [ck_pkg::CK_PIX_W-1:0]     in_blue;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ck_pkg::CK_PIX_W-1:0]     out_red;
  logic [ck_pkg::CK_PIX_W-1:0]     out_green;
  logic [ck_pkg::CK_PIX_W-1:0]     out_blue;
  logic [ck_pkg::CK_PIX_W-1:0]     out_alpha;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ck_pkg::CK_CFG_IDX_W-1:0] cfg_index;
  logic [ck_pkg::CK_DIST_W-1:0]    cfg_data;

  // Our own copy of the key color and radii, updated as each write is accepted.
  logic [ck_pkg::CK_PIX_W-1:0]  key_red_q   = ck_pkg::CK_RST_KEY_RED;
  logic [ck_pkg::CK_PIX_W-1:0]  key_green_q = ck_pkg::CK_RST_KEY_GREEN;
  logic [ck_pkg::CK_PIX_W-1:0]  key_blue_q  = ck_pkg::CK_RST_KEY_BLUE;
  logic [ck_pkg::CK_DIST_W-1:0] inner_sq_q  = ck_pkg::CK_RST_INNER_SQ;
  logic [ck_pkg::CK_DIST_W-1:0] outer_sq_q  = ck_pkg::CK_RST_OUTER_SQ;

  // Results the block still owes us, oldest first.
  keyed_pixel_t pending_pixels[$];
  int mismatches = 0;

  // Idle chances in percent for each side, and the remaining output hold-off.
  int idle_pct  = IDLE_PCT;
  int stall_pct = IDLE_PCT;
  int hold_left = 0;

  chroma_key_alpha_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Works out the result for one pixel under the current key and radii. The
  // squared distance is exact, so it never exceeds 195075 and fits in 18 bits.
  function automatic keyed_pixel_t predict_keyed_pixel(
      input logic [ck_pkg::CK_PIX_W-1:0] r,
      input logic [ck_pkg::CK_PIX_W-1:0] g,
      input logic [ck_pkg::CK_PIX_W-1:0] b);
    logic [ck_pkg::CK_PIX_W-1:0]  dr;
    logic [ck_pkg::CK_PIX_W-1:0]  dg;
    logic [ck_pkg::CK_PIX_W-1:0]  db;
    logic [ck_pkg::CK_DIST_W-1:0] sq_dist;
    longint unsigned              span;
    longint unsigned              ramp;
    keyed_pixel_t                 res;
    dr = (r > key_red_q)   ? r - key_red_q   : key_red_q - r;
    dg = (g > key_green_q) ? g - key_green_q : key_green_q - g;
    db = (b > key_blue_q)  ? b - key_blue_q  : key_blue_q - b;
    sq_dist = dr * dr + dg * dg + db * db;
    res.red   = r;
    res.green = g;
    res.blue  = b;
    if (sq_dist < inner_sq_q) begin
      res.alpha = ck_pkg::CK_ALPHA_CLEAR;
    end else if (sq_dist >= outer_sq_q) begin
      res.alpha = ck_pkg::CK_ALPHA_OPAQUE;
    end else begin
      // Inside the ramp outer is above inner, so the span is never zero.
      span = outer_sq_q - inner_sq_q;
      ramp = (64'd255 * (sq_dist - inner_sq_q)) / span;
      res.alpha = ramp[ck_pkg::CK_PIX_W-1:0];
    end
    return res;
  endfunction

  // Mirrors one accepted register write; unknown indexes change nothing.
  function automatic void apply_reg_write(input logic [ck_pkg::CK_CFG_IDX_W-1:0] idx,
                                          input logic [ck_pkg::CK_DIST_W-1:0] data);
    case (idx)
      ck_pkg::CK_REG_KEY_RED:   key_red_q   = data[ck_pkg::CK_PIX_W-1:0];
      ck_pkg::CK_REG_KEY_GREEN: key_green_q = data[ck_pkg::CK_PIX_W-1:0];
      ck_pkg::CK_REG_KEY_BLUE:  key_blue_q  = data[ck_pkg::CK_PIX_W-1:0];
      ck_pkg::CK_REG_INNER_SQ:  inner_sq_q  = data;
      ck_pkg::CK_REG_OUTER_SQ:  outer_sq_q  = data;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one pixel item. It is entered at a falling edge and returns at the
  // falling edge after acceptance with in_valid still high, so back-to-back
  // calls keep the channel busy, dropping valid only when an idle is drawn.
  task automatic send_pixel(input logic [ck_pkg::CK_PIX_W-1:0] r,
                            input logic [ck_pkg::CK_PIX_W-1:0] g,
                            input logic [ck_pkg::CK_PIX_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(predict_keyed_pixel(r, g, b));
    @(negedge clk);
  endtask

  // Ends the current stream and waits until every result has come back, then
  // lets the pipeline settle before anything else happens.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register and leaves cfg_valid high; the caller lowers it.
  task automatic cfg_write(input logic [ck_pkg::CK_CFG_IDX_W-1:0] idx,
                           input logic [ck_pkg::CK_DIST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(input logic [ck_pkg::CK_PIX_W-1:0] kr,
                             input logic [ck_pkg::CK_PIX_W-1:0] kg,
                             input logic [ck_pkg::CK_PIX_W-1:0] kb,
                             input logic [ck_pkg::CK_DIST_W-1:0] inner,
                             input logic [ck_pkg::CK_DIST_W-1:0] outer);
    wait_idle();
    cfg_write(ck_pkg::CK_REG_KEY_RED, kr);
    cfg_write(ck_pkg::CK_REG_KEY_GREEN, kg);
    cfg_write(ck_pkg::CK_REG_KEY_BLUE, kb);
    cfg_write(ck_pkg::CK_REG_INNER_SQ, inner);
    cfg_write(ck_pkg::CK_REG_OUTER_SQ, outer);
    cfg_valid <= 1'b0;
  endtask

  // A color byte within 80 of the key byte, clamped to the byte range, so that
  // random pixels land near the radii as often as far from them.
  function automatic logic [ck_pkg::CK_PIX_W-1:0] near_key(
      input logic [ck_pkg::CK_PIX_W-1:0] k);
    int v;
    v = int'(k) + int'($urandom_range(160)) - 80;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[ck_pkg::CK_PIX_W-1:0];
  endfunction

  // Reset register values: the key itself, both radii exactly, one step inside
  // each radius, the middle of the ramp, and the corners of the color cube.
  task automatic test_reset_defaults();
    send_pixel(8'd55, 8'd177, 8'd77);
    send_pixel(8'd134, 8'd177, 8'd77);
    send_pixel(8'd135, 8'd177, 8'd77);
    send_pixel(8'd155, 8'd177, 8'd77);
    send_pixel(8'd174, 8'd177, 8'd77);
    send_pixel(8'd175, 8'd177, 8'd77);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  // Keys at the corners of the cube with a ramp over the whole distance range,
  // so both the smallest and the largest distance are reached.
  task automatic test_extreme_keys();
    load_config(8'd0, 8'd0, 8'd0, '0, MAX_DIST_SQ);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    load_config(8'd255, 8'd255, 8'd255, '0, MAX_DIST_SQ);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  // Outer radius equal to or below the inner one: alpha jumps from 0 to 255.
  task automatic test_no_ramp();
    load_config(8'd100, 8'd100, 8'd100, 18'd2500, 18'd2500);
    send_pixel(8'd100, 8'd100, 8'd100);
    send_pixel(8'd149, 8'd100, 8'd100);
    send_pixel(8'd150, 8'd100, 8'd100);
    load_config(8'd100, 8'd100, 8'd100, 18'd2500, 18'd100);
    send_pixel(8'd149, 8'd100, 8'd100);
    send_pixel(8'd150, 8'd100, 8'd100);
  endtask

  // Radii at and beyond the largest reachable distance, up to all 18 bits set.
  task automatic test_wide_radii();
    load_config(8'd255, 8'd255, 8'd255, ALL_ONES_SQ, ALL_ONES_SQ);
    send_pixel(8'd0, 8'd0, 8'd0);
    load_config(8'd0, 8'd0, 8'd0, MAX_DIST_SQ, ALL_ONES_SQ);
    send_pixel(8'd255, 8'd255, 8'd255);
    load_config(8'd0, 8'd0, 8'd0, '0, ALL_ONES_SQ);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  // Key writes with the upper data bits set must keep only the low byte, and
  // writes to unused indexes must leave every register alone.
  task automatic test_register_masking();
    load_config(8'd10, 8'd20, 8'd30, 18'd400, 18'd3000);
    cfg_write(ck_pkg::CK_REG_KEY_RED, {10'h3FF, 8'd40});
    cfg_write(ck_pkg::CK_REG_KEY_GREEN, {10'h2AA, 8'd50});
    cfg_write(ck_pkg::CK_REG_KEY_BLUE, {10'h155, 8'd60});
    for (int i = ck_pkg::CK_REG_OUTER_SQ + 1; i < 2 ** ck_pkg::CK_CFG_IDX_W; i++) begin
      cfg_write(ck_pkg::CK_CFG_IDX_W'(i), ck_pkg::CK_DIST_W'($urandom));
    end
    cfg_valid <= 1'b0;
    send_pixel(8'd40, 8'd50, 8'd60);
    send_pixel(8'd70, 8'd50, 8'd60);
  endtask

  // Random phases, each under a fresh configuration drawn from a few shapes:
  // unrelated radii, a normal ramp, a span of a few units (largest quotients),
  // no ramp, arbitrary 18-bit radii and the full-range ramp. One phase runs
  // with no idling on either side.
  task automatic test_random_pixels();
    logic [ck_pkg::CK_DIST_W-1:0] inner;
    logic [ck_pkg::CK_DIST_W-1:0] outer;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(5))
        0: begin
          inner = ck_pkg::CK_DIST_W'($urandom_range(MAX_DIST_SQ));
          outer = ck_pkg::CK_DIST_W'($urandom_range(MAX_DIST_SQ));
        end
        1: begin
          inner = ck_pkg::CK_DIST_W'($urandom_range(40000));
          outer = ck_pkg::CK_DIST_W'(inner + $urandom_range(1, 30000));
        end
        2: begin
          inner = ck_pkg::CK_DIST_W'($urandom_range(20000));
          outer = ck_pkg::CK_DIST_W'(inner + $urandom_range(1, 8));
        end
        3: begin
          inner = ck_pkg::CK_DIST_W'($urandom_range(20000));
          outer = inner;
        end
        4: begin
          inner = ck_pkg::CK_DIST_W'($urandom);
          outer = ck_pkg::CK_DIST_W'($urandom);
        end
        default: begin
          inner = '0;
          outer = MAX_DIST_SQ;
        end
      endcase
      load_config(ck_pkg::CK_PIX_W'($urandom), ck_pkg::CK_PIX_W'($urandom),
                  ck_pkg::CK_PIX_W'($urandom), inner, outer);
      idle_pct  = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
      stall_pct = idle_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1)) begin
          send_pixel(ck_pkg::CK_PIX_W'($urandom), ck_pkg::CK_PIX_W'($urandom),
                     ck_pkg::CK_PIX_W'($urandom));
        end else begin
          send_pixel(near_key(key_red_q), near_key(key_green_q), near_key(key_blue_q));
        end
      end
    end
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // The output is held off for a long stretch while the input keeps offering
  // items, so the queue fills and the input stall must hold the stream.
  task automatic test_output_hold_off();
    wait_idle();
    idle_pct  = 0;
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 64; n++) begin
      send_pixel(near_key(key_red_q), near_key(key_green_q), ck_pkg::CK_PIX_W'($urandom));
    end
    idle_pct = IDLE_PCT;
  endtask

  // Receiver: a hold-off request wins; otherwise stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every accepted result is compared with the oldest expectation, field by
  // field. Block outputs are read at the rising edge before they update.
  always @(posedge clk) begin
    keyed_pixel_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d alpha %0d",
                                  out_red, out_green, out_blue, out_alpha));
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red !== exp_px.red)
          report_mismatch($sformatf("red %0d, expected %0d", out_red, exp_px.red));
        if (out_green !== exp_px.green)
          report_mismatch($sformatf("green %0d, expected %0d", out_green, exp_px.green));
        if (out_blue !== exp_px.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", out_blue, exp_px.blue));
        if (out_alpha !== exp_px.alpha)
          report_mismatch($sformatf("alpha %0d, expected %0d for %0d %0d %0d",
                                    out_alpha, exp_px.alpha,
                                    exp_px.red, exp_px.green, exp_px.blue));
      end
    end
  end

  // Stimulus and the final verdict. Reset is applied once, then each test runs
  // in turn; the block's registers start from their reset values.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_valid = 1'b0;
    cfg_index = ck_pkg::CK_REG_KEY_RED;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_extreme_keys();
    test_no_ramp();
    test_wide_radii();
    test_register_masking();
    test_random_pixels();
    test_output_hold_off();
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
